// ===== rtl/core/lssd_pkg.sv =====
package lssd_pkg;

    localparam int CNT_BITS           = 32;
    localparam int SUM_BITS           = CNT_BITS + 3;
    localparam int ACTIVE_FRAMES_DEF  = 5;
    localparam int SLEEP_FRAMES_DEF   = 2;
    localparam int CFG_IDX_BITS       = 3;
    localparam int CFG_DATA_BITS      = 17;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLEEP_EN     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLEEP_ANIM   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLEEP_THR    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAKE_THR     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUSY_FPS     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_FPS     = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLEEP_RATE   = 3'd7;

    typedef struct packed {
        logic        func;
        logic [31:0] user_count;
        logic [31:0] nice_count;
        logic [31:0] system_count;
        logic [31:0] idle_count;
        logic [31:0] iowait_count;
        logic [31:0] irq_count;
        logic [31:0] softirq_count;
        logic [31:0] steal_count;
        logic [15:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [16:0] smoothed_load;
        logic        asleep;
        logic [2:0]  frame_index;
        logic        frame_stepped;
        logic [9:0]  interval_ms;
    } t_out_item;

    typedef struct packed {
        logic [16:0] smoothing_weight;
        logic        sleep_enable;
        logic        sleep_animate;
        logic [6:0]  sleep_threshold_pct;
        logic [6:0]  wake_threshold_pct;
        logic [7:0]  busy_fps;
        logic [7:0]  idle_fps;
        logic [7:0]  sleep_rate;
    } t_cfg;

    typedef struct packed {
        logic                func;
        logic                primed;
        logic [SUM_BITS-1:0] used;
        logic [SUM_BITS-1:0] total;
        logic [15:0]         elapsed_ms;
    } t_job;

endpackage

// ===== rtl/core/lssd_front.sv =====
module lssd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lssd_pkg::t_in_item i_item,
    output lssd_pkg::t_job    o_job
);
    localparam int CB = lssd_pkg::CNT_BITS;
    localparam int SB = lssd_pkg::SUM_BITS;

    logic [CB-1:0] r_prev [8];
    logic          r_primed;
    logic [CB-1:0] cur [8];
    logic [SB-1:0] dx  [8];
    logic [SB-1:0] used;

    assign cur[0] = i_item.user_count;
    assign cur[1] = i_item.nice_count;
    assign cur[2] = i_item.system_count;
    assign cur[3] = i_item.idle_count;
    assign cur[4] = i_item.iowait_count;
    assign cur[5] = i_item.irq_count;
    assign cur[6] = i_item.softirq_count;
    assign cur[7] = i_item.steal_count;

    // wrapping deltas against the stored sample
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            dx[i] = {3'b000, cur[i] - r_prev[i]};
        end
        used = ((dx[0] + dx[1]) + (dx[2] + dx[5])) + (dx[6] + dx[7]);
    end

    always_comb begin
        o_job.func       = i_item.func;
        o_job.primed     = r_primed;
        o_job.used       = used;
        o_job.total      = used + (dx[3] + dx[4]);
        o_job.elapsed_ms = i_item.elapsed_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_prev[i] <= '0;
            end
        end else if (i_accept && i_item.func == lssd_pkg::FUNC_SAMPLE) begin
            r_primed <= 1'b1;
            for (int i = 0; i < 8; i++) begin
                r_prev[i] <= cur[i];
            end
        end
    end
endmodule

// ===== rtl/core/lssd_queue.sv =====
module lssd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr && !o_full) r_wp <= ~r_wp;
            if (i_rd && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_wr && !o_full} - {1'b0, i_rd && !o_empty};
        end
    end
endmodule

// ===== rtl/core/lssd_back.sv =====
module lssd_back #(
    parameter int ACTIVE_FRAMES = lssd_pkg::ACTIVE_FRAMES_DEF,
    parameter int SLEEP_FRAMES  = lssd_pkg::SLEEP_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lssd_pkg::t_job     i_job,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    input  lssd_pkg::t_cfg     i_cfg,
    output lssd_pkg::t_out_item o_res,
    output logic               o_res_valid,
    input  logic               i_res_pop
);
    localparam int SB    = lssd_pkg::SUM_BITS;
    localparam int MAXF  = (ACTIVE_FRAMES > SLEEP_FRAMES) ? ACTIVE_FRAMES : SLEEP_FRAMES;
    localparam int PW    = $clog2(MAXF + 1);
    localparam logic [9:0] ONE_K = 10'd1000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_EMA_MUL, ST_EMA_ADD, ST_THR,
        ST_RATE_MUL, ST_RATE, ST_IDIV, ST_TICK, ST_FIN
    } t_state;

    // reduce a small phase value by a constant frame count, parallel compares
    function automatic logic [PW-1:0] wrap_phase(input logic [PW-1:0] v, input int n);
        logic [PW-1:0] r;
        r = v;
        for (int k = 1; k <= MAXF; k++) begin
            if (int'(v) >= k * n) r = v - PW'(k * n);
        end
        return r;
    endfunction

    t_state         r_state;
    lssd_pkg::t_job r_job;
    logic [SB:0]    r_rem;
    logic [16:0]    r_q;
    logic [3:0]     r_cnt;
    logic [16:0]    r_load;
    logic           r_up;
    logic [33:0]    r_prod;
    logic [16:0]    r_sm;
    logic           r_sleep;
    logic [2:0]     r_below;
    logic [PW-1:0]  r_phase;
    logic [15:0]    r_tss;
    logic           r_never;
    logic [7:0]     r_mag;
    logic           r_neg;
    logic [7:0]     r_rate;
    logic [8:0]     r_irem;
    logic [9:0]     r_iq;
    logic [9:0]     r_interval;
    logic           r_stepped;
    lssd_pkg::t_out_item r_out;
    logic           r_out_valid;

    logic [16:0] w;
    logic [SB:0] rem2;
    logic        dge;
    logic        up;
    logic [16:0] dmag;
    logic [33:0] step_sum;
    logic [23:0] s100;
    logic [22:0] sleep_lim;
    logic [22:0] wake_lim;
    logic [8:0]  diff;
    logic [7:0]  adiff;
    logic [24:0] mprod;
    logic [9:0]  rate_s;
    logic [7:0]  rate_c;
    logic [8:0]  irem2;
    logic        ige;
    logic [16:0] tsum;
    logic [15:0] tsat;
    logic [PW-1:0] ph1;
    logic [PW-1:0] ph_next;
    logic [PW:0]   fidx;

    always_comb begin
        w        = (i_cfg.smoothing_weight > 17'd65536) ? 17'd65536 : i_cfg.smoothing_weight;
        rem2     = {r_rem[SB-1:0], 1'b0};
        dge      = rem2 >= {1'b0, r_job.total};
        up       = r_load >= r_sm;
        dmag     = up ? (r_load - r_sm) : (r_sm - r_load);
        step_sum = r_prod + 34'd32768;
        s100     = {7'd0, r_sm} * 24'd100;
        sleep_lim = {i_cfg.sleep_threshold_pct, 16'd0};
        wake_lim  = {i_cfg.wake_threshold_pct, 16'd0};
        diff     = {1'b0, i_cfg.busy_fps} - {1'b0, i_cfg.idle_fps};
        adiff    = diff[8] ? 8'(-diff) : diff[7:0];
        mprod    = {8'd0, r_sm} * {17'd0, adiff};
        rate_s   = r_neg ? ({2'b00, i_cfg.idle_fps} - {2'b00, r_mag})
                         : ({2'b00, i_cfg.idle_fps} + {2'b00, r_mag});
        if (rate_s[9] || rate_s == 10'd0) begin
            rate_c = 8'd1;
        end else if (rate_s[8]) begin
            rate_c = 8'd255;
        end else begin
            rate_c = rate_s[7:0];
        end
        irem2    = {r_irem[7:0], ONE_K[4'd9 - r_cnt]};
        ige      = irem2 >= {1'b0, r_rate};
        tsum     = {1'b0, r_tss} + {1'b0, r_job.elapsed_ms};
        tsat     = tsum[16] ? 16'hFFFF : tsum[15:0];
        ph1      = r_phase + PW'(1);
        ph_next  = r_sleep ? wrap_phase(ph1, SLEEP_FRAMES) : wrap_phase(ph1, ACTIVE_FRAMES);
        fidx     = r_sleep ? ((PW+1)'(ACTIVE_FRAMES) + {1'b0, wrap_phase(r_phase, SLEEP_FRAMES)})
                           : {1'b0, wrap_phase(r_phase, ACTIVE_FRAMES)};
    end

    assign o_job_pop   = (r_state == ST_IDLE) && i_job_valid;
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sm        <= '0;
            r_sleep     <= 1'b0;
            r_below     <= '0;
            r_phase     <= '0;
            r_tss       <= '0;
            r_never     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_FIN && (!r_out_valid || i_res_pop)) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_stepped <= 1'b0;
                    r_cnt     <= '0;
                    if (i_job_valid) begin
                        r_job <= i_job;
                        if (i_job.func == lssd_pkg::FUNC_TICK) begin
                            r_state <= ST_RATE_MUL;
                        end else if (!i_job.primed || i_job.total == '0) begin
                            r_load  <= '0;
                            r_state <= ST_EMA_MUL;
                        end else if (i_job.used >= i_job.total) begin
                            r_load  <= 17'd65536;
                            r_state <= ST_EMA_MUL;
                        end else begin
                            r_rem   <= {1'b0, i_job.used};
                            r_q     <= '0;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= dge ? (rem2 - {1'b0, r_job.total}) : rem2;
                    r_q   <= {r_q[15:0], dge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_load  <= {r_q[15:0], dge};
                        r_state <= ST_EMA_MUL;
                    end
                end
                ST_EMA_MUL: begin
                    r_up    <= up;
                    r_prod  <= {17'd0, dmag} * {17'd0, w};
                    r_state <= ST_EMA_ADD;
                end
                ST_EMA_ADD: begin
                    // step rounds half up in magnitude, applied toward the new share
                    r_sm    <= r_up ? (r_sm + step_sum[32:16]) : (r_sm - step_sum[32:16]);
                    r_state <= ST_THR;
                end
                ST_THR: begin
                    if (!i_cfg.sleep_enable) begin
                        r_sleep <= 1'b0;
                    end else if (r_sleep) begin
                        if (s100 > {1'b0, wake_lim}) begin
                            r_sleep <= 1'b0;
                            r_below <= '0;
                        end
                    end else if (s100 < {1'b0, sleep_lim}) begin
                        if (r_below >= 3'd3) r_sleep <= 1'b1;
                        if (r_below < 3'd4) r_below <= r_below + 3'd1;
                    end else begin
                        r_below <= '0;
                    end
                    r_state <= ST_RATE_MUL;
                end
                ST_RATE_MUL: begin
                    r_mag   <= mprod[23:16];
                    r_neg   <= diff[8];
                    r_state <= ST_RATE;
                end
                ST_RATE: begin
                    if (r_sleep) begin
                        r_rate <= (i_cfg.sleep_rate == 8'd0) ? 8'd1 : i_cfg.sleep_rate;
                    end else begin
                        r_rate <= rate_c;
                    end
                    r_irem  <= '0;
                    r_iq    <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_IDIV;
                end
                ST_IDIV: begin
                    r_irem <= ige ? (irem2 - {1'b0, r_rate}) : irem2;
                    r_iq   <= {r_iq[8:0], ige};
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd9) begin
                        r_interval <= {r_iq[8:0], ige};
                        r_state <= (r_job.func == lssd_pkg::FUNC_TICK) ? ST_TICK : ST_FIN;
                    end
                end
                ST_TICK: begin
                    if ((r_sleep && !i_cfg.sleep_animate)
                        || (!r_never && tsat < {6'd0, r_interval})) begin
                        r_tss <= tsat;
                    end else begin
                        r_tss     <= '0;
                        r_phase   <= ph_next;
                        r_never   <= 1'b0;
                        r_stepped <= 1'b1;
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_out_valid || i_res_pop) begin
                        r_out.smoothed_load <= r_sm;
                        r_out.asleep        <= r_sleep;
                        r_out.frame_index   <= fidx[2:0];
                        r_out.frame_stepped <= r_stepped;
                        r_out.interval_ms   <= r_interval;
                        r_state             <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/load_smoother_sleep_detector_top.sv =====
// A sample passes from its transfer in through the 16-step share divider, the smoothing
// multiply, the thresholds and the 10-step interval divider to the result register; a sample
// that needs no division (first, zero-total or full-load) skips the share divider, and a tick
// goes straight to the rate step, the interval divider and the frame step. The back engine
// holds one item at a time; a two-entry queue decouples the input and an unread result stalls it.
// Reset: synchronous, active low; clears history, smoothing, sleep and frame state, loads defaults.
module load_smoother_sleep_detector_top #(
    parameter int ACTIVE_FRAMES = lssd_pkg::ACTIVE_FRAMES_DEF,
    parameter int SLEEP_FRAMES  = lssd_pkg::SLEEP_FRAMES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  lssd_pkg::t_in_item                    i_item,
    output logic                                  empty,
    input  logic                                  pop,
    output lssd_pkg::t_out_item                   o_result,
    input  logic                                  i_cfg_we,
    input  logic [lssd_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [lssd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    lssd_pkg::t_cfg r_cfg;
    lssd_pkg::t_job front_job;
    lssd_pkg::t_job q_job;
    logic           q_empty;
    logic           job_pop;
    logic           res_valid;
    logic           accept;

    // an item transfers when push meets a non-full queue
    assign accept = push && !full;
    assign empty  = !res_valid;

    // configuration: plain write, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smoothing_weight    <= 17'd25786;
            r_cfg.sleep_enable        <= 1'b1;
            r_cfg.sleep_animate       <= 1'b1;
            r_cfg.sleep_threshold_pct <= 7'd8;
            r_cfg.wake_threshold_pct  <= 7'd12;
            r_cfg.busy_fps            <= 8'd30;
            r_cfg.idle_fps            <= 8'd2;
            r_cfg.sleep_rate          <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lssd_pkg::CFG_WEIGHT:     r_cfg.smoothing_weight    <= i_cfg_data;
                lssd_pkg::CFG_SLEEP_EN:   r_cfg.sleep_enable        <= i_cfg_data[0];
                lssd_pkg::CFG_SLEEP_ANIM: r_cfg.sleep_animate       <= i_cfg_data[0];
                lssd_pkg::CFG_SLEEP_THR:  r_cfg.sleep_threshold_pct <= i_cfg_data[6:0];
                lssd_pkg::CFG_WAKE_THR:   r_cfg.wake_threshold_pct  <= i_cfg_data[6:0];
                lssd_pkg::CFG_BUSY_FPS:   r_cfg.busy_fps            <= i_cfg_data[7:0];
                lssd_pkg::CFG_IDLE_FPS:   r_cfg.idle_fps            <= i_cfg_data[7:0];
                lssd_pkg::CFG_SLEEP_RATE: r_cfg.sleep_rate          <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // front: take deltas and busy sums as the item is accepted
    lssd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_job    (front_job)
    );

    // hold classified jobs until the back engine is free
    lssd_queue #(.WIDTH($bits(lssd_pkg::t_job))) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (front_job),
        .i_rd    (job_pop),
        .o_data  (q_job),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // back: divide, smooth, apply hysteresis, step frames, register the result
    lssd_back #(
        .ACTIVE_FRAMES (ACTIVE_FRAMES),
        .SLEEP_FRAMES  (SLEEP_FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_valid (!q_empty),
        .o_job_pop   (job_pop),
        .i_cfg       (r_cfg),
        .o_res       (o_result),
        .o_res_valid (res_valid),
        .i_res_pop   (pop)
    );
endmodule

// ===== rtl/core/lssd_checker.sv =====
module lssd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               push,
    input logic                               full,
    input lssd_pkg::t_in_item                 i_item,
    input logic                               empty,
    input logic                               pop,
    input lssd_pkg::t_out_item                o_result,
    input logic                               i_cfg_we,
    input logic [lssd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input logic [lssd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result dropped or changed");

    a_interval_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.interval_ms >= 10'd3 && o_result.interval_ms <= 10'd1000))
        else $error("frame interval out of range");

    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.smoothed_load <= 17'd65536))
        else $error("smoothed load above full scale");
endmodule

bind load_smoother_sleep_detector_top lssd_checker u_lssd_checker (.*);
